// ===== src/aee_pkg.sv =====
// shared types, constants and register codes for the airtime ewma estimator
`default_nettype none
package aee_pkg;

    // widths and defaults
    localparam int TIME_BITS_DEF = 48;
    localparam int OUT_TIME_W    = 48;
    localparam int CNT_W         = 32;
    localparam int CWSUM_W       = 48;
    localparam int W_W           = 17;
    localparam int Q_W           = 18;
    localparam int DIV_W         = 43;
    localparam int DSTEP_W       = 5;
    localparam int MUL_STEPS     = 17;
    localparam int PADDR_W       = 4;
    localparam int RATIO_STEPS   = 18;
    localparam int CW_STEPS      = 16;
    localparam int RND_HALF      = 32768;

    // register indexes (byte address / 4)
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ENABLE = 2'd0;
    localparam t_reg_idx REG_PERIOD = 2'd1;
    localparam t_reg_idx REG_WEIGHT = 2'd2;

    // register reset values and limits
    localparam logic [31:0]    PERIOD_RST = 32'd100000000;
    localparam logic [W_W-1:0] WEIGHT_RST = 17'd52429;
    localparam logic [W_W-1:0] WEIGHT_ONE = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TXN,
        S_ACC,
        S_MUL_GO,
        S_MUL_WAIT,
        S_SMOOTH,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_CW_GO,
        S_CW_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic           enable;
        logic [31:0]    period_ns;
        logic [W_W-1:0] history_weight;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [DSTEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage
`default_nettype wire

// ===== src/aee_if.sv =====
// valid/ready channel interfaces for input and result words
`default_nettype none
interface aee_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        is_data;
    logic [9:0]  contention_window;
    logic [15:0] slot_ns;
    logic [15:0] sifs_ns;
    logic [15:0] difs_ns;
    logic [19:0] rts_ns;
    logic [19:0] cts_ns;
    logic [23:0] frame_ns;
    logic [19:0] mac_ack_ns;
    logic        past_stop;

    modport source (
        output valid, op, is_data, contention_window, slot_ns, sifs_ns, difs_ns,
               rts_ns, cts_ns, frame_ns, mac_ack_ns, past_stop,
        input  ready
    );
    modport sink (
        input  valid, op, is_data, contention_window, slot_ns, sifs_ns, difs_ns,
               rts_ns, cts_ns, frame_ns, mac_ack_ns, past_stop,
        output ready
    );
endinterface

interface aee_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] period_index;
    logic [47:0] raw_active_ns;
    logic [47:0] prior_smoothed_ns;
    logic [47:0] smoothed_ns;
    logic [17:0] bandwidth_ratio;
    logic [31:0] data_count;
    logic [31:0] ack_count;
    logic [15:0] average_cw;
    logic [47:0] backoff_sum_ns;
    logic [47:0] rts_sum_ns;
    logic [47:0] cts_sum_ns;
    logic [47:0] interframe_sum_ns;

    modport source (
        output valid, period_index, raw_active_ns, prior_smoothed_ns, smoothed_ns,
               bandwidth_ratio, data_count, ack_count, average_cw, backoff_sum_ns,
               rts_sum_ns, cts_sum_ns, interframe_sum_ns,
        input  ready
    );
    modport sink (
        input  valid, period_index, raw_active_ns, prior_smoothed_ns, smoothed_ns,
               bandwidth_ratio, data_count, ack_count, average_cw, backoff_sum_ns,
               rts_sum_ns, cts_sum_ns, interframe_sum_ns,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/aee_cfg.sv =====
// apb configuration registers
`default_nettype none
module aee_cfg
    import aee_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.period_ns      <= PERIOD_RST;
            r_cfg.history_weight <= WEIGHT_RST;
        end else if (wr) begin
            case (idx)
                REG_ENABLE: r_cfg.enable         <= pwdata[0];
                REG_PERIOD: r_cfg.period_ns      <= pwdata;
                REG_WEIGHT: r_cfg.history_weight <= pwdata[W_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_ENABLE: prdata = {31'd0, r_cfg.enable};
            REG_PERIOD: prdata = r_cfg.period_ns;
            REG_WEIGHT: prdata = {15'd0, r_cfg.history_weight};
            default:    prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/aee_mul.sv =====
// shift-add unit for the weighted sum w*s + (1-w)*raw, one weight bit a cycle
`default_nettype none
module aee_mul
    import aee_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [TIME_BITS-1:0]     i_hist,
    input  wire logic [TIME_BITS-1:0]     i_raw,
    input  wire logic [W_W-1:0]           i_w,
    input  wire logic [W_W-1:0]           i_u,
    output logic      [TIME_BITS+W_W-1:0] o_prod,
    output t_unit_sts                     o_sts
);

    localparam int PW = TIME_BITS + W_W;

    logic [PW-1:0]      r_acc;
    logic [W_W-1:0]     r_w;
    logic [W_W-1:0]     r_u;
    logic [DSTEP_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [PW-1:0]      step_sum;

    // msb-first accumulate of both weighted terms
    assign step_sum = {r_acc[PW-2:0], 1'b0}
                    + (r_w[W_W-1] ? PW'(i_hist) : '0)
                    + (r_u[W_W-1] ? PW'(i_raw) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DSTEP_W'(MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DSTEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_w   <= i_w;
            r_u   <= i_u;
        end else if (r_busy) begin
            r_acc <= step_sum;
            r_w   <= {r_w[W_W-2:0], 1'b0};
            r_u   <= {r_u[W_W-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;
    assign o_sts  = '{busy: r_busy, done: r_done};

endmodule
`default_nettype wire

// ===== src/aee_div.sv =====
// restoring divider for fractions num/den with num < den, one quotient bit a cycle
`default_nettype none
module aee_div
    import aee_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [DIV_W-1:0] i_den,
    output logic      [Q_W-1:0]   o_quot,
    output t_unit_sts             o_sts
);

    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_den;
    logic [Q_W-1:0]     r_quot;
    logic [DSTEP_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_W:0]     rem2;
    logic [DIV_W:0]     diff;
    logic               ge;

    // shared compare and subtract
    assign rem2 = {r_rem, 1'b0};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DSTEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
            r_quot <= {r_quot[Q_W-2:0], ge};
        end
    end

    assign o_quot = r_quot;
    assign o_sts  = '{busy: r_busy, done: r_done};

endmodule
`default_nettype wire

// ===== src/airtime_ewma_estimator.sv =====
// top level: sequencer, period accumulators and result register
//
// channel   dir  handshake        word
// i_in      in   valid/ready      transaction or period close
// o_out     out  valid/ready      period report
// apb       in   psel/penable     enable, period_ns, history_weight
//
// a transaction steps through accept, backoff multiply and accumulate
// a reported close runs the shift-add weighting, then the two divisions on
// the shared divider (each skipped when its result saturates), plus
// sequencing; it holds longer while a report waits
// a close that is ignored or marks the stop goes no further than the idle state
// reset is synchronous; the next word is taken while a report waits at o_out
`default_nettype none
module airtime_ewma_estimator
    import aee_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    aee_in_if.sink                  i_in,
    aee_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int PW = TIME_BITS + W_W;

    t_cfg      cfg;
    t_state    r_state, n_state;
    t_div_req  div_req;
    t_unit_sts div_sts, mul_sts;
    logic      mul_start;

    // latched transaction fields
    logic              r_is_data;
    logic [9:0]        r_cw;
    logic [15:0]       r_slot, r_sifs, r_difs;
    logic [19:0]       r_rts, r_cts, r_mack;
    logic [23:0]       r_frame;
    logic [24:0]       r_backoff;
    logic [17:0]       r_ifs;
    logic [24:0]       r_extra;

    // period state
    logic [TIME_BITS-1:0] r_raw, r_smooth, r_prior;
    logic [TIME_BITS-1:0] r_bo_sum, r_rts_sum, r_cts_sum, r_ifs_sum;
    logic [CWSUM_W-1:0]   r_cw_sum;
    logic [CNT_W-1:0]     r_data_cnt, r_ack_cnt, r_period;
    logic                 r_stopped;
    logic [Q_W-1:0]       r_ratio;
    logic [15:0]          r_avg;
    logic                 r_ovalid;

    logic                 in_acc;
    logic [W_W-1:0]       w_clamp, u_comp;
    logic [PW-1:0]        prod;
    logic [PW:0]          rnd;
    logic [DIV_W-1:0]     div_num, div_den;
    logic [Q_W-1:0]       quot;
    logic [CNT_W:0]       pk;
    logic [DIV_W-1:0]     cw_den;
    logic                 ratio_sat, cw_sat;
    logic [26:0]          total;
    logic                 emit_ok;

    function automatic logic [TIME_BITS-1:0] sat_t(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [CWSUM_W-1:0] sat_cw(input logic [CWSUM_W-1:0] a,
                                                  input logic [CWSUM_W-1:0] b);
        logic [CWSUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CWSUM_W] ? '1 : s[CWSUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    function automatic logic [OUT_TIME_W-1:0] to_out(input logic [TIME_BITS-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[OUT_TIME_W-1:0];
    endfunction

    aee_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // weight clamp to one
    assign w_clamp = (cfg.history_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.history_weight;
    assign u_comp  = WEIGHT_ONE - w_clamp;

    aee_mul #(.TIME_BITS(TIME_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_hist  (r_smooth),
        .i_raw   (r_raw),
        .i_w     (w_clamp),
        .i_u     (u_comp),
        .o_prod  (prod),
        .o_sts   (mul_sts)
    );

    aee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (quot),
        .o_sts   (div_sts)
    );

    // saturation checks and divider operands
    assign ratio_sat = (cfg.period_ns == '0) ||
                       (64'(r_smooth) >= 64'({cfg.period_ns, 2'b00}));
    assign pk        = {1'b0, r_data_cnt} + {1'b0, r_ack_cnt};
    assign cw_den    = {pk, 10'd0};
    assign cw_sat    = r_cw_sum >= CWSUM_W'(cw_den);
    assign div_num   = (r_state == S_RATIO_GO) ? DIV_W'(r_smooth) : DIV_W'(r_cw_sum);
    assign div_den   = (r_state == S_RATIO_GO) ? DIV_W'({cfg.period_ns, 2'b00}) : cw_den;

    assign rnd     = {1'b0, prod} + (PW + 1)'(RND_HALF);
    assign total   = 27'(r_backoff) + 27'(r_ifs) + 27'(r_extra);
    assign in_acc  = i_in.valid && i_in.ready;
    assign emit_ok = !r_ovalid || o_out.ready;

    assign i_in.ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and unit starts
    always_comb begin
        n_state       = r_state;
        mul_start     = 1'b0;
        div_req.start = 1'b0;
        div_req.steps = DSTEP_W'(RATIO_STEPS);
        case (r_state)
            S_IDLE: begin
                if (in_acc && cfg.enable) begin
                    if (!i_in.op) begin
                        n_state = S_TXN;
                    end else if (!r_stopped && !i_in.past_stop) begin
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_TXN:    n_state = S_ACC;
            S_ACC:    n_state = S_IDLE;
            S_MUL_GO: begin
                mul_start = 1'b1;
                n_state   = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mul_sts.done) begin
                    n_state = S_SMOOTH;
                end
            end
            S_SMOOTH: n_state = S_RATIO_GO;
            S_RATIO_GO: begin
                if (ratio_sat) begin
                    n_state = S_CW_GO;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_RATIO_WAIT;
                end
            end
            S_RATIO_WAIT: begin
                if (div_sts.done) begin
                    n_state = S_CW_GO;
                end
            end
            S_CW_GO: begin
                div_req.steps = DSTEP_W'(CW_STEPS);
                if (pk == '0 || cw_sat) begin
                    n_state = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_CW_WAIT;
                end
            end
            S_CW_WAIT: begin
                if (div_sts.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // input capture and per-transaction terms
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_is_data <= i_in.is_data;
            r_cw      <= i_in.contention_window;
            r_slot    <= i_in.slot_ns;
            r_sifs    <= i_in.sifs_ns;
            r_difs    <= i_in.difs_ns;
            r_rts     <= i_in.rts_ns;
            r_cts     <= i_in.cts_ns;
            r_frame   <= i_in.frame_ns;
            r_mack    <= i_in.mac_ack_ns;
        end
        if (r_state == S_TXN) begin
            r_backoff <= 25'((26'(r_cw) * 26'(r_slot)) >> 1);
            r_ifs     <= 18'(r_sifs) + 18'(r_sifs) + 18'(r_sifs) + 18'(r_difs);
            r_extra   <= 25'(r_frame) + 25'(r_rts) + 25'(r_cts) + 25'(r_mack);
        end
    end

    // period accumulators, smoothing and stop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw      <= '0;
            r_smooth   <= '0;
            r_bo_sum   <= '0;
            r_rts_sum  <= '0;
            r_cts_sum  <= '0;
            r_ifs_sum  <= '0;
            r_cw_sum   <= '0;
            r_data_cnt <= '0;
            r_ack_cnt  <= '0;
            r_period   <= '0;
            r_stopped  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && cfg.enable && i_in.op && i_in.past_stop) begin
                        r_stopped <= 1'b1;
                    end
                end
                S_ACC: begin
                    if (r_is_data) begin
                        r_data_cnt <= sat_inc(r_data_cnt);
                    end else begin
                        r_ack_cnt <= sat_inc(r_ack_cnt);
                    end
                    r_raw     <= sat_t(r_raw, TIME_BITS'(total));
                    r_cw_sum  <= sat_cw(r_cw_sum, CWSUM_W'(r_cw));
                    r_bo_sum  <= sat_t(r_bo_sum, TIME_BITS'(r_backoff));
                    r_rts_sum <= sat_t(r_rts_sum, TIME_BITS'(r_rts));
                    r_cts_sum <= sat_t(r_cts_sum, TIME_BITS'(r_cts));
                    r_ifs_sum <= sat_t(r_ifs_sum, TIME_BITS'(r_ifs));
                end
                S_SMOOTH: begin
                    r_smooth <= (|rnd[PW:PW-1]) ? '1 : rnd[PW-2:W_W-1];
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_period   <= r_period + 1'b1;
                        r_raw      <= '0;
                        r_bo_sum   <= '0;
                        r_rts_sum  <= '0;
                        r_cts_sum  <= '0;
                        r_ifs_sum  <= '0;
                        r_cw_sum   <= '0;
                        r_data_cnt <= '0;
                        r_ack_cnt  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // prior value, ratio and average cw
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL_GO:     r_prior <= r_smooth;
            S_RATIO_GO:   r_ratio <= '1;
            S_RATIO_WAIT: begin
                if (div_sts.done) begin
                    r_ratio <= quot;
                end
            end
            S_CW_GO:      r_avg <= (pk == '0) ? 16'd0 : 16'hFFFF;
            S_CW_WAIT: begin
                if (div_sts.done) begin
                    r_avg <= quot[15:0];
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_EMIT && emit_ok) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_ok) begin
            o_out.period_index      <= r_period;
            o_out.raw_active_ns     <= to_out(r_raw);
            o_out.prior_smoothed_ns <= to_out(r_prior);
            o_out.smoothed_ns       <= to_out(r_smooth);
            o_out.bandwidth_ratio   <= r_ratio;
            o_out.data_count        <= r_data_cnt;
            o_out.ack_count         <= r_ack_cnt;
            o_out.average_cw        <= r_avg;
            o_out.backoff_sum_ns    <= to_out(r_bo_sum);
            o_out.rts_sum_ns        <= to_out(r_rts_sum);
            o_out.cts_sum_ns        <= to_out(r_cts_sum);
            o_out.interframe_sum_ns <= to_out(r_ifs_sum);
        end
    end

    assign o_out.valid = r_ovalid;

    // checks
    a_stop_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stop flag cleared");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_sts.done |-> (r_state == S_MUL_WAIT))
        else $error("multiply finished outside its wait state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_RATIO_WAIT || r_state == S_CW_WAIT))
        else $error("divide finished outside its wait state");

    a_period_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && emit_ok) |=> (r_period == $past(r_period) + 1'b1))
        else $error("period number did not advance with a report");

endmodule
`default_nettype wire
